### sv/assert_macros.svh
// Assertion macros for the checker file mexp_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset)
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### sv/mexp_pkg.sv
// Package for the modular exponentiation block: widths, word types, register
// indexes and the request/response structs of the bit-serial modular multiplier.
`default_nettype none

package mexp_pkg;

    // Datapath width; operands are cut to this many low bits
    localparam int OPERAND_WIDTH = 32;
    // Bit counter width for one scan over the operand
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    // Configuration register indexes
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    typedef logic [OPERAND_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;
    // Partial sum before reduction stays below 3n < 2^(W+2)
    typedef logic [OPERAND_WIDTH+1:0] t_ext;

    // Request into a modular multiplier
    typedef struct packed {
        logic  start;
        t_word op_a;
        t_word op_b;
    } t_mm_req;

    // Response from a modular multiplier
    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mm_rsp;

endpackage

`default_nettype wire

### sv/modular_exponentiation.sv
// Top level of the modular exponentiation block: config registers and the
// square-and-multiply sequencer. Depends on mexp_pkg and mexp_mulmod.
//
// Usage:
//   Config: write modulus (index 0) and exponent (index 1) through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle. Reset sets
//   modulus to 1 and exponent to 0.
//   Request: a base is taken on i_base_value at a clock edge where start
//   is high and busy is low. busy stays high until the result is shown.
//   Result: o_power_result = base^exponent mod modulus, shown for exactly
//   one cycle with o_valid high. The receiver cannot stall; the result
//   must be captured in that cycle. A zero modulus gives 0.
//   Sequence: the base is first reduced on one bit-serial multiplier, then
//   each exponent bit runs one squaring and one multiply in parallel on two
//   bit-serial multipliers. The next request can be taken at the edge that
//   takes the result.
//   One request is in flight at a time. Reset is synchronous, active low,
//   and drops any request in progress.
`default_nettype none

module modular_exponentiation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_base_value,
    output logic             o_valid,
    output logic [31:0]      o_power_result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_BITGO  = 3'd2;
    localparam logic [2:0] ST_BITWT  = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [31:0]        r_modulus;
    logic [31:0]        r_exponent;
    logic [2:0]         r_state;
    logic               r_valid;
    logic [31:0]        r_result;
    mexp_pkg::t_cnt     r_bitcnt;
    mexp_pkg::t_word    r_e;
    mexp_pkg::t_word    r_acc;
    mexp_pkg::t_word    r_run;

    mexp_pkg::t_word    w_n;
    mexp_pkg::t_word    w_one;
    mexp_pkg::t_mm_req  w_sq_req;
    mexp_pkg::t_mm_req  w_ml_req;
    mexp_pkg::t_mm_rsp  w_sq_rsp;
    mexp_pkg::t_mm_rsp  w_ml_rsp;
    logic               w_accept;

    assign w_n      = r_modulus[mexp_pkg::OPERAND_WIDTH-1:0];
    assign w_one    = mexp_pkg::OPERAND_WIDTH'(1);
    assign w_accept = start && (r_state == ST_IDLE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= 32'd1;
            r_exponent <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mexp_pkg::CFG_MODULUS:  r_modulus  <= i_cfg_data;
                mexp_pkg::CFG_EXPONENT: r_exponent <= i_cfg_data;
                default:                r_modulus  <= r_modulus;
            endcase
        end
    end

    // Multiplier requests: unit 0 reduces the base, then squares the
    // running base; unit 1 multiplies the running base into the result.
    always_comb begin
        w_sq_req.start = 1'b0;
        w_sq_req.op_a  = r_run;
        w_sq_req.op_b  = r_run;
        w_ml_req.start = (r_state == ST_BITGO);
        w_ml_req.op_a  = r_acc;
        w_ml_req.op_b  = r_run;
        if (w_accept && (w_n != '0)) begin
            w_sq_req.start = 1'b1;
            w_sq_req.op_a  = i_base_value[mexp_pkg::OPERAND_WIDTH-1:0];
            w_sq_req.op_b  = w_one;
        end else if (r_state == ST_BITGO) begin
            w_sq_req.start = 1'b1;
        end
    end

    mexp_mulmod u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (w_n),
        .i_req     (w_sq_req),
        .o_rsp     (w_sq_rsp)
    );

    mexp_mulmod u_ml (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (w_n),
        .i_req     (w_ml_req),
        .o_rsp     (w_ml_rsp)
    );

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_bitcnt <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_bitcnt <= mexp_pkg::CNT_W'(mexp_pkg::OPERAND_WIDTH - 1);
                        r_state  <= (w_n == '0) ? ST_FIN : ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (w_sq_rsp.done) begin
                        r_state <= ST_BITGO;
                    end
                end
                ST_BITGO: begin
                    r_state <= ST_BITWT;
                end
                ST_BITWT: begin
                    if (w_sq_rsp.done && w_ml_rsp.done) begin
                        r_bitcnt <= r_bitcnt - 1'b1;
                        r_state  <= (r_bitcnt == '0) ? ST_FIN : ST_BITGO;
                    end
                end
                ST_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Operand registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e   <= r_exponent[mexp_pkg::OPERAND_WIDTH-1:0];
            // 1 mod n; zero for n of 0 or 1
            r_acc <= (w_n > w_one) ? w_one : '0;
        end
        if ((r_state == ST_REDUCE) && w_sq_rsp.done) begin
            r_run <= w_sq_rsp.prod;
        end
        if ((r_state == ST_BITWT) && w_sq_rsp.done && w_ml_rsp.done) begin
            r_run <= w_sq_rsp.prod;
            r_e   <= r_e >> 1;
            if (r_e[0]) begin
                r_acc <= w_ml_rsp.prod;
            end
        end
        if (r_state == ST_FIN) begin
            r_result <= 32'(r_acc);
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_power_result = r_result;

endmodule

`default_nettype wire

### sv/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: (a * b) mod n, one bit of a
// per cycle, MSB first. Depends on mexp_pkg.
`default_nettype none

module mexp_mulmod (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mexp_pkg::t_word i_modulus,
    input  wire mexp_pkg::t_mm_req i_req,
    output mexp_pkg::t_mm_rsp    o_rsp
);

    logic               r_busy;
    logic               r_done;
    mexp_pkg::t_cnt     r_cnt;
    mexp_pkg::t_word    r_a;
    mexp_pkg::t_word    r_b;
    mexp_pkg::t_word    r_r;

    mexp_pkg::t_ext     w_sum;
    mexp_pkg::t_ext     w_n1;
    mexp_pkg::t_ext     w_n2;
    mexp_pkg::t_ext     w_red;

    // r = 2r + a_i * b, then bring back below n (sum is below 3n)
    always_comb begin
        w_sum = {1'b0, r_r, 1'b0}
              + {2'b00, (r_a[mexp_pkg::OPERAND_WIDTH-1] ? r_b : '0)};
        w_n1  = {2'b00, i_modulus};
        w_n2  = {1'b0, i_modulus, 1'b0};
        if (w_sum >= w_n2) begin
            w_red = w_sum - w_n2;
        end else if (w_sum >= w_n1) begin
            w_red = w_sum - w_n1;
        end else begin
            w_red = w_sum;
        end
    end

    // Control: one bit per cycle, done pulses after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= mexp_pkg::CNT_W'(mexp_pkg::OPERAND_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift and accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.op_a;
            r_b <= i_req.op_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[mexp_pkg::OPERAND_WIDTH-2:0], 1'b0};
            r_r <= w_red[mexp_pkg::OPERAND_WIDTH-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_r;

endmodule

`default_nettype wire

### sv/mexp_checker.sv
// Port-level checker for modular_exponentiation, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mexp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // Result strobe lasts a single cycle
    `ASSERT_SYNC(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid)
    // An accepted request makes the block busy
    `ASSERT_SYNC(a_req_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    // A result only follows a request in progress
    `ASSERT_SYNC(a_valid_after_busy, i_clk, i_rst_n, o_valid |-> $past(busy))
    // Reset leaves the block idle with no result
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_valid))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire

### test/modular_exponentiation_tb.sv
// Self-checking testbench for modular_exponentiation: base^exponent mod modulus.
// Depends on mexp_pkg and the modular_exponentiation RTL; checks every result
// against an in-bench square-and-multiply predictor.
`timescale 1ns / 100ps

module modular_exponentiation_tb;

    // Cycles with no accepted request or result before the run is abandoned
    localparam int IDLE_LIMIT  = 20000;
    // Quiet time after the last result
    localparam int TAIL_CYCLES = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic [31:0] i_base_value;
    logic        o_valid;
    logic [31:0] o_power_result;

    // Bench copy of the key registers, mirrors what was written to the block
    mexp_pkg::t_word cur_modulus;
    mexp_pkg::t_word cur_exponent;
    // Predicted powers, oldest first
    mexp_pkg::t_word pending_powers[$];
    int    error_count = 0;
    int    stall_count = 0;
    int    idle_pct    = 10;

    modular_exponentiation u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_base_value   (i_base_value),
        .o_valid        (o_valid),
        .o_power_result (o_power_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Right-to-left square-and-multiply with a 64-bit product
    function automatic mexp_pkg::t_word expected_power(input mexp_pkg::t_word base,
                                                       input mexp_pkg::t_word exp_v,
                                                       input mexp_pkg::t_word mod_v);
        logic [63:0] acc;
        logic [63:0] run;
        if (mod_v == '0)
            return '0;
        acc = 64'd1 % 64'(mod_v);
        run = 64'(base) % 64'(mod_v);
        for (int i = 0; i < mexp_pkg::OPERAND_WIDTH; i++) begin
            if (exp_v[i])
                acc = (acc * run) % 64'(mod_v);
            run = (run * run) % 64'(mod_v);
        end
        return mexp_pkg::t_word'(acc);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Present one base; the sender drops start at random per idle_pct
    task automatic send_base(input mexp_pkg::t_word b);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
            end else begin
                start        <= 1'b1;
                i_base_value <= 32'(b);
            end
            @(posedge i_clk);
            taken = start && !busy;
        end
        pending_powers.push_back(expected_power(b, cur_exponent, cur_modulus));
    endtask

    // Stop requesting and wait until every predicted power has come back
    task automatic finish_requests();
        start <= 1'b0;
        while (pending_powers.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    // Write both key registers back to back; block must be idle
    task automatic load_key(input mexp_pkg::t_word mod_v, input mexp_pkg::t_word exp_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mexp_pkg::CFG_MODULUS;
        i_cfg_data <= 32'(mod_v);
        @(posedge i_clk);
        i_cfg_idx  <= mexp_pkg::CFG_EXPONENT;
        i_cfg_data <= 32'(exp_v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_modulus  = mod_v;
        cur_exponent = exp_v;
    endtask

    function automatic mexp_pkg::t_word pick_modulus();
        mexp_pkg::t_word m;
        case ($urandom_range(7))
            0:       m = 1;
            1:       m = 2;
            2:       m = '1;
            3:       m = $urandom_range(255, 3);
            4:       m = $urandom_range(32'hFFFF, 256);
            default: m = $urandom;
        endcase
        return (m == '0) ? mexp_pkg::t_word'(1) : m;
    endfunction

    function automatic mexp_pkg::t_word pick_exponent();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 1;
            2:       return '1;
            3:       return mexp_pkg::t_word'(1)
                            << $urandom_range(mexp_pkg::OPERAND_WIDTH - 1);
            4:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // Mostly full-range bases, plus values around the modulus
    function automatic mexp_pkg::t_word pick_base();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return cur_modulus;
            3:       return cur_modulus - 1;
            4:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // Reset values: modulus 1, exponent 0, so every power is 0
    task automatic test_reset_values();
        send_base('0);
        send_base('1);
        send_base(5);
        finish_requests();
    endtask

    // Zero exponent gives 1, also for a zero base and an unreduced base
    task automatic test_zero_exponent();
        load_key('1, '0);
        send_base('0);
        send_base(1);
        send_base('1);
        finish_requests();
    endtask

    // Modulus of one gives 0 whatever the base and exponent
    task automatic test_unit_modulus();
        load_key(1, '1);
        send_base('0);
        send_base(32'd123);
        send_base('1);
        finish_requests();
    endtask

    // Widest modulus and exponent, bases below and at the modulus
    task automatic test_operand_extremes();
        load_key('1, '1);
        send_base('0);
        send_base(1);
        send_base(2);
        send_base(32'hFFFF_FFFE);
        send_base('1);
        send_base(32'h8000_0000);
        finish_requests();
        // Largest 32-bit prime; base above the modulus must be reduced first
        load_key(32'hFFFF_FFFB, 1);
        send_base('1);
        send_base(32'd12345);
        finish_requests();
        load_key(32'hFFFF_FFFB, 2);
        send_base(32'hFFFF_FFFA);
        finish_requests();
        // Only the top exponent bit set
        load_key(2, 32'h8000_0000);
        send_base(3);
        finish_requests();
    endtask

    // Random bases under a fresh random key every dozen requests
    task automatic run_random_traffic(input int pct, input int n_items);
        idle_pct = pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 12 == 0) begin
                finish_requests();
                load_key(pick_modulus(), pick_exponent());
            end
            send_base(pick_base());
        end
        finish_requests();
    endtask

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        mexp_pkg::t_word want;
        if (i_rst_n && o_valid) begin
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("result %h with no request pending",
                                          o_power_result));
            end else begin
                want = pending_powers.pop_front();
                if (o_power_result !== 32'(want))
                    report_mismatch($sformatf("power_result %h, predicted %h",
                                              o_power_result, want));
            end
        end
    end

    // Watchdog on cycles with neither an accepted request nor a result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= mexp_pkg::CFG_MODULUS;
        i_cfg_data   <= '0;
        start        <= 1'b0;
        i_base_value <= '0;
        cur_modulus  = 1;
        cur_exponent = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_zero_exponent();
        test_unit_modulus();
        test_operand_extremes();
        run_random_traffic(10, 87);
        run_random_traffic(68, 87);
        run_random_traffic(0, 87);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
